// ===== design/nfba_pkg.sv =====
// ----------------------------------------------------------------------------
// nfba_pkg
// Shared constants and controller/datapath interface types for the next-fit
// block allocator.
// ----------------------------------------------------------------------------
package nfba_pkg;

	localparam int MAX_BLOCKS = 16;
	localparam int IDX_W      = 4;   // width of a block index field
	localparam int SIZE_W     = 16;  // width of a size field
	localparam int COUNT_W    = 5;   // width of the block_count register

	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(16);
	localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(MAX_BLOCKS);

	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_REQUEST = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // write one block size into the table
		logic start;   // latch the request and set up the scan
		logic step;    // advance the scan to the next block
		logic commit;  // write the result and update the table on a hit
	} nfba_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hit;     // the block under the scan pointer fits
		logic last;    // no further block remains to be examined
	} nfba_status_t;

endpackage

// ===== design/nfba_ctrl.sv =====
// ----------------------------------------------------------------------------
// nfba_ctrl
// Controller state machine: accepts items, sequences the circular scan and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module nfba_ctrl import nfba_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic         kind,
	output logic         m_tvalid,
	input  logic         m_tready,
	output nfba_cmd_t    cmd,
	input  nfba_status_t status
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   accept;
	logic   out_free;
	logic   finish;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;
	assign finish   = status.hit || status.last;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.start  = 1'b0;
		cmd.step   = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && kind == KIND_LOAD) begin
					cmd.load = 1'b1;
				end else if (accept) begin
					cmd.start = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (finish) begin
					// Hold here until the result register can take the result.
					if (out_free) begin
						cmd.commit = 1'b1;
						state_d    = ST_IDLE;
					end
				end else begin
					cmd.step = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

endmodule

// ===== design/nfba_dp.sv =====
// ----------------------------------------------------------------------------
// nfba_dp
// Datapath: free size table, rover, block count register, scan pointer and
// result register.
// ----------------------------------------------------------------------------
module nfba_dp import nfba_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [COUNT_W-1:0]  cfg_count,
	input  nfba_cmd_t           cmd,
	output nfba_status_t        status,
	input  logic [IDX_W-1:0]    block_index,
	input  logic [SIZE_W-1:0]   block_size,
	input  logic [SIZE_W-1:0]   request_size,
	output logic                granted,
	output logic [IDX_W-1:0]    granted_index,
	output logic [SIZE_W-1:0]   granted_size
);

	logic [SIZE_W-1:0]  free_q [MAX_BLOCKS];
	logic [IDX_W-1:0]   rover_q;
	logic [COUNT_W-1:0] block_count_q;
	logic [COUNT_W-1:0] active_q;     // saturated count latched at request start
	logic [COUNT_W-1:0] remain_q;     // blocks still to examine, current one included
	logic [IDX_W-1:0]   idx_q;
	logic [SIZE_W-1:0]  req_q;

	logic [COUNT_W-1:0] active_d;
	logic [IDX_W-1:0]   start_idx;
	logic [COUNT_W-1:0] idx_inc;
	logic [IDX_W-1:0]   idx_next;
	logic [SIZE_W-1:0]  cur_size;

	assign active_d  = (block_count_q > COUNT_MAX) ? COUNT_MAX : block_count_q;
	assign start_idx = ({1'b0, rover_q} < active_d) ? rover_q : '0;

	assign idx_inc  = {1'b0, idx_q} + COUNT_W'(1);
	assign idx_next = (idx_inc < active_q) ? idx_inc[IDX_W-1:0] : '0;
	assign cur_size = free_q[idx_q];

	// With an empty count nothing is examined, so no hit can be raised.
	assign status.hit  = (remain_q != '0) && (cur_size > req_q);
	assign status.last = (remain_q <= COUNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_BLOCKS; i++) begin
				free_q[i] <= '0;
			end
			rover_q       <= '0;
			block_count_q <= COUNT_RESET;
		end else begin
			if (cfg_we) begin
				block_count_q <= cfg_count;
			end
			if (cmd.load && ({1'b0, block_index} < (IDX_W+1)'(MAX_BLOCKS))) begin
				free_q[block_index] <= block_size;
			end
			if (cmd.commit && status.hit) begin
				free_q[idx_q] <= '0;
				rover_q       <= idx_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			active_q <= active_d;
			remain_q <= active_d;
			idx_q    <= start_idx;
			req_q    <= request_size;
		end else if (cmd.step) begin
			remain_q <= remain_q - COUNT_W'(1);
			idx_q    <= idx_next;
		end
		if (cmd.commit) begin
			granted       <= status.hit;
			granted_index <= status.hit ? idx_q : '0;
			granted_size  <= status.hit ? cur_size : '0;
		end
	end

endmodule

// ===== design/next_fit_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// next_fit_block_allocator_unit
// Next-fit allocator over a table of free block sizes with a roving pointer.
// ----------------------------------------------------------------------------
// A load transaction (s_tuser kind = 0) writes one block size into the table
// and produces no result. A request transaction (kind = 1) scans the first
// block_count blocks circularly from the rover, one block per cycle through
// the single table read port, and takes the first block whose size is
// strictly greater than the request. The result transaction reports the block
// index and its former size, the block is zeroed and the rover moves past it;
// if nothing fits the result is a refusal with index and size zero and no
// state changes. A new item is accepted in the cycle after the result is
// registered. The result waits in an output register, so the scan of the
// next request runs while an earlier result is still pending; a finished scan
// holds only if the previous result has not yet been taken. block_count values
// above MAX_BLOCKS act as MAX_BLOCKS, a count of zero refuses every request,
// and the count is to be written only while the unit is idle. The table
// resets to all zero.
// ----------------------------------------------------------------------------
module next_fit_block_allocator_unit import nfba_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // block_index[3:0], block_size[19:4],
	                               // request_size[35:20], zero pad [39:36]
	input  logic [0:0]  s_tuser,   // kind[0]
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // granted_index[3:0], granted_size[19:4],
	                               // zero pad [23:20]
	output logic [0:0]  m_tuser,   // granted[0]
	// Configuration write channel for block_count.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data
);

	nfba_cmd_t         cmd;
	nfba_status_t      status;
	logic              granted;
	logic [IDX_W-1:0]  granted_index;
	logic [SIZE_W-1:0] granted_size;

	// The user must write the register only while idle; the block does not enforce it, so the write is always taken.
	assign cfg_ready = 1'b1;

	nfba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.kind     (s_tuser[0]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.status   (status)
	);

	nfba_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_count     (cfg_data),
		.cmd           (cmd),
		.status        (status),
		.block_index   (s_tdata[3:0]),
		.block_size    (s_tdata[19:4]),
		.request_size  (s_tdata[35:20]),
		.granted       (granted),
		.granted_index (granted_index),
		.granted_size  (granted_size)
	);

	assign m_tuser = granted;
	assign m_tdata = {4'b0000, granted_size, granted_index};

endmodule
